// File: hdl/least_loaded_dispatch_rebalance_top_macros.svh
// Assertion macros shared by the dispatch block.
`ifndef LEAST_LOADED_DISPATCH_REBALANCE_TOP_MACROS_SVH
`define LEAST_LOADED_DISPATCH_REBALANCE_TOP_MACROS_SVH
// Checks that the consequent holds in the same cycle as the antecedent.
`define LLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define LLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/lld_pkg.sv
// Types and constants of the least-loaded dispatch block.
package lld_pkg;
	localparam int TAG_W = 16;
	localparam int ADDR_W = 3;

	localparam logic [2:0] ST_ASSIGNED = 3'd0;
	localparam logic [2:0] ST_HANDED = 3'd1;
	localparam logic [2:0] ST_MOVED = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_DROPPED = 3'd4;

	localparam logic REG_WORKER_COUNT = 1'b0;
	localparam logic REG_WATERLINE = 1'b1;

	localparam logic KIND_ADD = 1'b0;

	typedef struct packed {
		logic             kind;
		logic [2:0]       worker;
		logic [TAG_W-1:0] task_tag;
	} item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       target_worker;
		logic [2:0]       source_worker;
		logic [TAG_W-1:0] tag_out;
		logic             last;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_step;
		logic add_push;
		logic take_check;
		logic tag_latch;
		logic div_init;
		logic div_step;
		logic decide;
		logic move_pop;
		logic move_push;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic take_empty;
		logic rebal;
		logic move_last;
	} stat_t;
endpackage

// File: hdl/lld_ctrl.sv
// Sequencer that steps the dispatch datapath through one item.
module lld_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          kind,
	output logic          busy,
	output lld_pkg::cmd_t cmd,
	input  lld_pkg::stat_t stat
);
	import lld_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_SCAN   = 11'b00000000010,
		S_ADD    = 11'b00000000100,
		S_TCHK   = 11'b00000001000,
		S_TLAT   = 11'b00000010000,
		S_DINIT  = 11'b00000100000,
		S_DIV    = 11'b00001000000,
		S_DECIDE = 11'b00010000000,
		S_MPOP   = 11'b00100000000,
		S_MLAT   = 11'b01000000000,
		S_MPUSH  = 11'b10000000000
	} state_t;

	typedef enum logic [1:0] {
		RET_ADD  = 2'd0,
		RET_TAKE = 2'd1,
		RET_MOVE = 2'd2
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (kind == KIND_ADD) begin
						cmd.scan_init = 1'b1;
						ret_d = RET_ADD;
						state_d = S_SCAN;
					end else begin
						state_d = S_TCHK;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					case (ret_q)
						RET_ADD: state_d = S_ADD;
						RET_TAKE: state_d = S_DINIT;
						default: state_d = S_MPUSH;
					endcase
				end
			end
			S_ADD: begin
				cmd.add_push = 1'b1;
				state_d = S_IDLE;
			end
			S_TCHK: begin
				cmd.take_check = 1'b1;
				state_d = stat.take_empty ? S_IDLE : S_TLAT;
			end
			S_TLAT: begin
				cmd.tag_latch = 1'b1;
				cmd.scan_init = 1'b1;
				ret_d = RET_TAKE;
				state_d = S_SCAN;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = stat.rebal ? S_MPOP : S_IDLE;
			end
			S_MPOP: begin
				cmd.move_pop = 1'b1;
				state_d = S_MLAT;
			end
			S_MLAT: begin
				cmd.tag_latch = 1'b1;
				cmd.scan_init = 1'b1;
				ret_d = RET_MOVE;
				state_d = S_SCAN;
			end
			S_MPUSH: begin
				cmd.move_push = 1'b1;
				state_d = stat.move_last ? S_IDLE : S_MPOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= RET_ADD;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

// File: hdl/lld_dp.sv
// Datapath with the queue store, counts, load scan, divider and result register.
`include "least_loaded_dispatch_rebalance_top_macros.svh"
module lld_dp #(
	parameter int WORKERS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lld_pkg::item_t   item,
	input  logic [3:0]       worker_count,
	input  logic [4:0]       waterline,
	input  lld_pkg::cmd_t    cmd,
	output lld_pkg::stat_t   stat,
	output lld_pkg::result_t res,
	output logic             res_valid
);
	import lld_pkg::*;

	localparam int WI = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int NW = $clog2(WORKERS + 1);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int SUM_W = $clog2(WORKERS * QUEUE_DEPTH + 1);
	localparam int DCW = $clog2(SUM_W + 1);
	localparam int AW = $clog2(WORKERS * QUEUE_DEPTH);
	localparam int DEPTH = WORKERS * QUEUE_DEPTH;

	item_t            item_q;
	logic [CW-1:0]    cnt_q [WORKERS];
	logic [HW-1:0]    head_q [WORKERS];
	logic [TAG_W-1:0] mem_q [DEPTH];
	logic [TAG_W-1:0] rdata_q;
	logic [TAG_W-1:0] tag_q;
	logic [WI-1:0]    idx_q, least_q, busy_idx_q;
	logic [CW-1:0]    least_cnt_q, top_q, moves_q;
	logic [SUM_W-1:0] sum_q, dq_q;
	logic [NW-1:0]    rem_q;
	logic [DCW-1:0]   dcnt_q;
	result_t          res_q;
	logic             res_valid_q;

	logic [NW-1:0]    n_act;
	logic [WI-1:0]    w_idx, sel;
	logic [CW-1:0]    cnt_rd;
	logic [HW-1:0]    head_rd, head_inc, slot;
	logic [CW:0]      slot_sum;
	logic [AW-1:0]    waddr, raddr;
	logic             w_out, full, push, pop;
	logic [NW:0]      rem_sh;
	logic             ge;

	always_comb begin
		if (worker_count == 4'd0) begin
			n_act = NW'(1);
		end else if (32'(worker_count) > WORKERS) begin
			n_act = NW'(WORKERS);
		end else begin
			n_act = NW'(worker_count);
		end
	end

	assign w_idx = WI'(item_q.worker);
	assign w_out = 32'(item_q.worker) >= WORKERS;
	assign sel = cmd.scan_step ? idx_q :
		(cmd.add_push || cmd.move_push) ? least_q : w_idx;
	assign cnt_rd = cnt_q[sel];
	assign head_rd = head_q[sel];
	assign full = 32'(cnt_rd) >= QUEUE_DEPTH;
	assign slot_sum = (CW + 1)'(head_rd) + (CW + 1)'(cnt_rd);
	assign slot = (32'(slot_sum) >= QUEUE_DEPTH) ? HW'(32'(slot_sum) - QUEUE_DEPTH)
		: HW'(slot_sum);
	assign head_inc = (32'(head_rd) == QUEUE_DEPTH - 1) ? '0 : HW'(32'(head_rd) + 1);
	assign waddr = AW'(32'(sel) * QUEUE_DEPTH + 32'(slot));
	assign raddr = AW'(32'(sel) * QUEUE_DEPTH + 32'(head_rd));

	assign stat.take_empty = w_out || (cnt_rd == '0);
	assign push = (cmd.add_push || cmd.move_push) && !full;
	assign pop = (cmd.take_check && !stat.take_empty) || cmd.move_pop;

	assign stat.scan_last = (idx_q == WI'(32'(n_act) - 1));
	assign rem_sh = {rem_q, dq_q[SUM_W-1]};
	assign ge = rem_sh >= (NW + 1)'(n_act);
	assign stat.div_last = (dcnt_q == DCW'(SUM_W - 1));
	assign stat.rebal = (32'(item_q.worker) < 32'(n_act)) && (w_idx == busy_idx_q)
		&& (32'(cnt_rd) > 32'(waterline)) && (32'(cnt_rd) > 32'(dq_q));
	assign stat.move_last = (moves_q == CW'(1));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[waddr] <= (cmd.add_push) ? item_q.task_tag : tag_q;
		end
		if (pop) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORKERS; i++) begin
				cnt_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else if (push) begin
			cnt_q[sel] <= cnt_rd + CW'(1);
		end else if (pop) begin
			cnt_q[sel] <= cnt_rd - CW'(1);
			head_q[sel] <= head_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.tag_latch) begin
			tag_q <= rdata_q;
		end
		if (cmd.scan_init) begin
			idx_q <= '0;
			least_q <= '0;
			busy_idx_q <= '0;
			top_q <= '0;
			least_cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + WI'(1);
			sum_q <= sum_q + SUM_W'(cnt_rd);
			if (idx_q == '0 || cnt_rd < least_cnt_q) begin
				least_q <= idx_q;
				least_cnt_q <= cnt_rd;
			end
			if (cnt_rd > top_q) begin
				busy_idx_q <= idx_q;
				top_q <= cnt_rd;
			end
		end
		if (cmd.div_init) begin
			dq_q <= sum_q;
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? NW'(rem_sh - (NW + 1)'(n_act)) : NW'(rem_sh);
			dq_q <= {dq_q[SUM_W-2:0], ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if (cmd.decide) begin
			moves_q <= CW'(32'(cnt_rd) - 32'(dq_q));
		end else if (cmd.move_push) begin
			moves_q <= moves_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_push) begin
			res_q.status <= full ? ST_DROPPED : ST_ASSIGNED;
			res_q.target_worker <= 3'(least_q);
			res_q.source_worker <= '0;
			res_q.tag_out <= item_q.task_tag;
			res_q.last <= 1'b1;
		end else if (cmd.take_check) begin
			res_q.status <= ST_EMPTY;
			res_q.target_worker <= item_q.worker;
			res_q.source_worker <= '0;
			res_q.tag_out <= '0;
			res_q.last <= 1'b1;
		end else if (cmd.decide) begin
			res_q.status <= ST_HANDED;
			res_q.target_worker <= item_q.worker;
			res_q.source_worker <= '0;
			res_q.tag_out <= tag_q;
			res_q.last <= !stat.rebal;
		end else begin
			res_q.status <= full ? ST_DROPPED : ST_MOVED;
			res_q.target_worker <= 3'(least_q);
			res_q.source_worker <= item_q.worker;
			res_q.tag_out <= tag_q;
			res_q.last <= stat.move_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.add_push || cmd.decide || cmd.move_push
				|| (cmd.take_check && stat.take_empty);
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	`LLD_ASSERT_NOW(a_move_pending, cmd.move_push, moves_q != '0, "move without pending count")
	`LLD_ASSERT_NOW(a_rebal_nonempty, cmd.decide && stat.rebal, cnt_rd != '0,
		"rebalance from empty queue")
	`LLD_ASSERT_NEXT(a_last_gap, res_valid_q && res_q.last, !res_valid_q,
		"result beat straight after final beat")
endmodule

// File: hdl/least_loaded_dispatch_rebalance_top.sv
// Top level of the least-loaded dispatch block with its register port.
// An add pushes its tag to the least-loaded active worker; a take pops a tag and then
// averages loads in the bit-serial divider and may move tags to the least-loaded worker.
// Items are handled one at a time: start is taken only while busy is low.
// Results cannot be stalled; each beat shows for one cycle on res_valid.
// Reset clears all queues and sets worker_count to 8 and waterline to 4.
module least_loaded_dispatch_rebalance_top #(
	parameter int WORKERS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lld_pkg::item_t              item,
	output logic                        res_valid,
	output lld_pkg::result_t            res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lld_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import lld_pkg::*;

	logic [3:0] worker_count_q;
	logic [4:0] waterline_q;
	cmd_t       cmd;
	stat_t      stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worker_count_q <= 4'd8;
			waterline_q <= 5'd4;
		end else if (psel && penable && pwrite) begin
			case (paddr[ADDR_W-1])
				REG_WORKER_COUNT: worker_count_q <= pwdata[3:0];
				REG_WATERLINE: waterline_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1])
			REG_WORKER_COUNT: prdata = {28'd0, worker_count_q};
			REG_WATERLINE: prdata = {27'd0, waterline_q};
			default: prdata = '0;
		endcase
	end

	lld_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	lld_dp #(
		.WORKERS     (WORKERS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.worker_count (worker_count_q),
		.waterline    (waterline_q),
		.cmd          (cmd),
		.stat         (stat),
		.res          (res),
		.res_valid    (res_valid)
	);
endmodule
